[rtl/core/csched_pkg.sv]
package csched_pkg;

    localparam int NUM_FLOORS = 16;
    localparam int FLOOR_W    = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam int FIELD_FL_W = 4;
    localparam int DIR_W      = 2;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam logic CALL_HALL = 1'b0;
    localparam logic CALL_CAR  = 1'b1;

    typedef logic [NUM_FLOORS-1:0] stop_map_t;

    typedef struct packed {
        logic                  op;
        logic                  call_type;
        logic [DIR_W-1:0]      call_direction;
        logic [FIELD_FL_W-1:0] floor;
    } call_t;

    typedef struct packed {
        stop_map_t          up_map;
        stop_map_t          down_map;
        logic [FLOOR_W-1:0] cur_floor;
        logic [DIR_W-1:0]   direction;
    } car_state_t;

    typedef struct packed {
        logic [FIELD_FL_W-1:0] car_floor;
        logic [DIR_W-1:0]      car_direction;
        logic                  rejected;
    } status_t;

endpackage

[rtl/core/csched_call_if.sv]
interface csched_call_if
    import csched_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic                  call_type;
    logic [DIR_W-1:0]      call_direction;
    logic [FIELD_FL_W-1:0] floor;

    modport source (output valid, output op, output call_type, output call_direction,
                    output floor, input ready);
    modport sink   (input valid, input op, input call_type, input call_direction,
                    input floor, output ready);
endinterface

[rtl/core/csched_status_if.sv]
interface csched_status_if
    import csched_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FIELD_FL_W-1:0] car_floor;
    logic [DIR_W-1:0]      car_direction;
    logic                  rejected;

    modport source (output valid, output car_floor, output car_direction,
                    output rejected, input ready);
    modport sink   (input valid, input car_floor, input car_direction,
                    input rejected, output ready);
endinterface

[rtl/core/csched_step.sv]
// Next state and status for one item: booking or one tick of movement.
module csched_step
    import csched_pkg::*;
(
    input  call_t      item,
    input  car_state_t cur,
    output car_state_t nxt,
    output status_t    status
);
    stop_map_t          above_mask;
    stop_map_t          below_mask;
    stop_map_t          book_bit;
    stop_map_t          clr_bit;
    logic               want_up;
    logic               want_down;
    logic               rejected;
    logic [DIR_W-1:0]   call_dir;
    logic [FLOOR_W-1:0] new_floor;

    always_comb
    begin
        above_mask = (~stop_map_t'(0) << cur.cur_floor) << 1;
        below_mask = (stop_map_t'(1) << cur.cur_floor) - stop_map_t'(1);
        want_up    = |(cur.up_map & above_mask);
        want_down  = |(cur.down_map & below_mask);
        rejected   = (int'(item.floor) >= NUM_FLOORS);
        book_bit   = stop_map_t'(1) << item.floor;

        // hall calls carry their own direction; code three counts as none
        if (item.call_type == CALL_HALL)
        begin
            if (item.call_direction == DIR_UP || item.call_direction == DIR_DOWN)
                call_dir = item.call_direction;
            else
                call_dir = DIR_NONE;
        end
        else if (int'(item.floor) == int'(cur.cur_floor))
            call_dir = DIR_NONE;
        else if (int'(item.floor) > int'(cur.cur_floor))
            call_dir = DIR_UP;
        else
            call_dir = DIR_DOWN;

        nxt       = cur;
        new_floor = cur.cur_floor;
        if (want_up)
            new_floor = cur.cur_floor + FLOOR_W'(1);
        else if (want_down)
            new_floor = cur.cur_floor - FLOOR_W'(1);
        clr_bit = ~(stop_map_t'(1) << new_floor);

        if (item.op == OP_ADD)
        begin
            if (!rejected)
            begin
                nxt.direction = call_dir;
                if (call_dir == DIR_DOWN)
                    nxt.down_map = cur.down_map | book_bit;
                else
                    nxt.up_map = cur.up_map | book_bit;
            end
        end
        else
        begin
            if (want_up)
                nxt.direction = DIR_UP;
            else if (want_down)
                nxt.direction = DIR_DOWN;
            else
                nxt.direction = DIR_NONE;
            nxt.cur_floor = new_floor;
            nxt.up_map    = cur.up_map & clr_bit;
            nxt.down_map  = cur.down_map & clr_bit;
        end

        status.car_floor     = FIELD_FL_W'(nxt.cur_floor);
        status.car_direction = nxt.direction;
        status.rejected      = (item.op == OP_ADD) && rejected;
    end
endmodule

[rtl/core/car_stop_scheduler.sv]
// Lift car stop scheduler. Each item on the call channel is either an add
// call (hall or car call booking a stop) or a tick (move one floor up if an
// up stop is booked above, else down if a down stop is booked below, and
// clear the stops at the new floor). Every item yields exactly one status
// item: floor after the item, last direction, and a rejected flag for add
// calls naming a floor beyond the building. An item is captured in an input
// register; one short pass of mask and reduction logic over the two stop
// maps computes the next state and the status, which lands in the output
// register, and status is valid once it sits there. Throughput is one item
// per cycle while the status sink keeps up, set by that single pass of
// stop-map logic. The call channel stays ready while the status register is
// being drained, so the two sides do not wait on each other except when the
// status sink stalls.
module car_stop_scheduler
    import csched_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    csched_call_if.sink     call,
    csched_status_if.source status
);
    // input register
    logic       in_valid_reg;
    call_t      in_item_reg;

    // car state
    car_state_t state_reg;
    car_state_t state_next;

    // result register
    logic       out_valid_reg;
    status_t    out_reg;
    status_t    out_next;

    logic       advance;

    // the held item moves on when the status slot is empty or being taken
    assign advance    = in_valid_reg && (!out_valid_reg || status.ready);
    assign call.ready = !in_valid_reg || advance;

    csched_step u_step (
        .item   (in_item_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .status (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (call.ready)
                in_valid_reg <= call.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (status.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (call.ready && call.valid)
        begin
            in_item_reg.op             <= call.op;
            in_item_reg.call_type      <= call.call_type;
            in_item_reg.call_direction <= call.call_direction;
            in_item_reg.floor          <= call.floor;
        end
        if (advance)
            out_reg <= out_next;
    end

    assign status.valid         = out_valid_reg;
    assign status.car_floor     = out_reg.car_floor;
    assign status.car_direction = out_reg.car_direction;
    assign status.rejected      = out_reg.rejected;
endmodule

[sim/csched_checker.sv]
module csched_checker
    import csched_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    csched_call_if   call,
    csched_status_if status,
    output int       mismatches,
    output int       statuses_due
);

    // Predicted car state
    stop_map_t          up_stops;
    stop_map_t          down_stops;
    logic [FLOOR_W-1:0] car_at;
    logic [DIR_W-1:0]   heading;

    status_t due_status[$];
    int      statuses_seen;

    // Applies one call item to the predicted car and returns the status it yields.
    function automatic status_t advance_car(input call_t c);
        status_t          s;
        logic [DIR_W-1:0] dir;
        logic             up_target;
        logic             down_target;
        s = '0;
        if (c.op == OP_ADD)
        begin
            if (int'(c.floor) >= NUM_FLOORS)
            begin
                s.rejected = 1'b1;
            end
            else
            begin
                if (c.call_type == CALL_HALL)
                    dir = (c.call_direction == DIR_UP || c.call_direction == DIR_DOWN)
                          ? c.call_direction : DIR_NONE;
                else if (int'(c.floor) == int'(car_at))
                    dir = DIR_NONE;
                else
                    dir = (int'(c.floor) > int'(car_at)) ? DIR_UP : DIR_DOWN;
                if (dir == DIR_DOWN)
                    down_stops[c.floor] = 1'b1;
                else
                    up_stops[c.floor] = 1'b1;
                heading = dir;
            end
        end
        else
        begin
            // up stops below and down stops above never count as targets
            up_target   = 1'b0;
            down_target = 1'b0;
            for (int i = 0; i < NUM_FLOORS; i++)
            begin
                if (i > int'(car_at) && up_stops[i])
                    up_target = 1'b1;
                if (i < int'(car_at) && down_stops[i])
                    down_target = 1'b1;
            end
            if (up_target)
            begin
                heading = DIR_UP;
                car_at  = car_at + FLOOR_W'(1);
            end
            else if (down_target)
            begin
                heading = DIR_DOWN;
                car_at  = car_at - FLOOR_W'(1);
            end
            else
            begin
                heading = DIR_NONE;
            end
            up_stops[car_at]   = 1'b0;
            down_stops[car_at] = 1'b0;
        end
        s.car_floor     = FIELD_FL_W'(car_at);
        s.car_direction = heading;
        return s;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("status item %0d: %s", statuses_seen, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_stops      = '0;
            down_stops    = '0;
            car_at        = '0;
            heading       = DIR_NONE;
            mismatches    = 0;
            statuses_seen = 0;
            due_status.delete();
            statuses_due  = 0;
        end
        else
        begin : watch
            status_t got;
            status_t want;
            call_t   item;
            if (status.valid && status.ready)
            begin
                got.car_floor     = status.car_floor;
                got.car_direction = status.car_direction;
                got.rejected      = status.rejected;
                if (due_status.size() == 0)
                begin
                    flag_mismatch("arrived with no call item outstanding");
                end
                else
                begin
                    want = due_status.pop_front();
                    if (got.car_floor !== want.car_floor)
                        flag_mismatch($sformatf("car_floor is %0d, expected %0d",
                                                got.car_floor, want.car_floor));
                    if (got.car_direction !== want.car_direction)
                        flag_mismatch($sformatf("car_direction is %0d, expected %0d",
                                                got.car_direction, want.car_direction));
                    if (got.rejected !== want.rejected)
                        flag_mismatch($sformatf("rejected is %0d, expected %0d",
                                                got.rejected, want.rejected));
                end
                statuses_seen++;
            end
            if (call.valid && call.ready)
            begin
                item.op             = call.op;
                item.call_type      = call.call_type;
                item.call_direction = call.call_direction;
                item.floor          = call.floor;
                due_status.push_back(advance_car(item));
            end
            statuses_due = due_status.size();
        end
    end

endmodule

[sim/car_stop_scheduler_tb.sv]
module car_stop_scheduler_tb;
    import csched_pkg::*;

    // Give up once this many cycles pass with no item moving on either channel.
    // The long receiver hold-off below is far shorter, so this sits well clear.
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;

    csched_call_if   call_ch ();
    csched_status_if status_ch ();

    int mismatches;
    int statuses_due;

    // Set by the stimulus, taken up by the receiver process.
    bit hold_req;

    int items_sent;
    int burst_left;

    car_stop_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .call   (call_ch),
        .status (status_ch)
    );

    csched_checker status_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .call         (call_ch),
        .status       (status_ch),
        .mismatches   (mismatches),
        .statuses_due (statuses_due)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Call item builders
    // ------------------------------------------------------------------
    function automatic call_t hall_call(input logic [DIR_W-1:0] dir,
                                        input logic [FIELD_FL_W-1:0] fl);
        call_t c;
        c.op             = OP_ADD;
        c.call_type      = CALL_HALL;
        c.call_direction = dir;
        c.floor          = fl;
        return c;
    endfunction

    function automatic call_t car_call(input logic [FIELD_FL_W-1:0] fl);
        call_t c;
        c.op             = OP_ADD;
        c.call_type      = CALL_CAR;
        c.call_direction = DIR_W'($urandom_range(0, 3));    // ignored on a car call
        c.floor          = fl;
        return c;
    endfunction

    // Tick with junk in the unused fields, so the block is seen to ignore them.
    function automatic call_t tick_call();
        call_t c;
        c.op             = OP_TICK;
        c.call_type      = 1'($urandom_range(0, 1));
        c.call_direction = DIR_W'($urandom_range(0, 3));
        c.floor          = FIELD_FL_W'($urandom_range(0, 15));
        return c;
    endfunction

    // Any item at all; add_only restricts it to bookings.
    function automatic call_t random_call(input bit add_only);
        call_t c;
        c.op             = add_only ? OP_ADD : 1'($urandom_range(0, 1));
        c.call_type      = 1'($urandom_range(0, 1));
        c.call_direction = DIR_W'($urandom_range(0, 3));
        c.floor          = FIELD_FL_W'($urandom_range(0, 15));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after
    // the item is taken. Items go out in bursts; between bursts valid
    // drops for a random gap. Some bursts are long, giving gap-free runs.
    // ------------------------------------------------------------------
    task automatic offer(input call_t c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            call_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        call_ch.valid          <= 1'b1;
        call_ch.op             <= c.op;
        call_ch.call_type      <= c.call_type;
        call_ch.call_direction <= c.call_direction;
        call_ch.floor          <= c.floor;
        @(posedge clk);
        while (!call_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, switching between always-ready,
    // mostly-ready, a fixed one-in-three stall and coin-toss. A hold
    // request parks ready low so the block backs up and stalls the
    // call channel.
    // ------------------------------------------------------------------
    initial
    begin : status_drain
        int hold_left;
        int mode;
        int cyc;
        hold_left       = 0;
        mode            = 0;
        cyc             = 0;
        status_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                status_ch.ready <= 1'b0;
            end
            else begin
                case (mode)
                    0:       status_ch.ready <= 1'b1;
                    1:       status_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       status_ch.ready <= (cyc % 3 != 0);
                    default: status_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run that stops moving items is a failure.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (call_ch.valid && call_ch.ready) ||
                (status_ch.valid && status_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bit held;
        bit paused;
        int n;
        held       = 1'b0;
        paused     = 1'b0;
        items_sent = 0;
        burst_left = 0;

        call_ch.valid          = 1'b0;
        call_ch.op             = OP_ADD;
        call_ch.call_type      = CALL_HALL;
        call_ch.call_direction = DIR_NONE;
        call_ch.floor          = '0;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Tick with nothing booked, then a car call at the
        // current floor (no direction, cleared by the next tick without moving).
        offer(tick_call());
        offer(car_call(4'd0));
        offer(tick_call());
        // Hall calls: both extremes of the floor range, every direction code
        // including the unused code three, which books as no direction.
        offer(hall_call(DIR_UP, 4'd15));
        offer(hall_call(DIR_DOWN, 4'd0));
        offer(hall_call(DIR_NONE, 4'd5));
        offer(hall_call(2'd3, 4'd10));
        offer(hall_call(DIR_DOWN, 4'd7));
        offer(car_call(4'd3));
        repeat (5) offer(tick_call());
        // Car call below the car derives down; an up hall call below the car
        // is never served while the car sits above it.
        offer(car_call(4'd1));
        offer(hall_call(DIR_UP, 4'd2));
        repeat (6) offer(tick_call());

        // Random part: mostly trips (a few bookings, then a run of ticks so
        // the car actually travels), the rest loose random items.
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!held && items_sent >= 500) begin
                // Long receiver hold-off while the sender keeps going.
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && items_sent >= 1000) begin
                // Sender stops until every outstanding status has come back.
                paused = 1'b1;
                call_ch.valid <= 1'b0;
                @(negedge clk);
                wait (statuses_due == 0);
                @(negedge clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(1, 4);
                repeat (n) offer(random_call(1'b1));
                n = $urandom_range(1, 20);
                repeat (n) offer(tick_call());
            end
            else begin
                n = $urandom_range(1, 10);
                repeat (n) offer(random_call(1'b0));
            end
        end

        call_ch.valid <= 1'b0;
        wait (statuses_due == 0);
        // A spare wait catches any stray status item.
        repeat (10) @(posedge clk);

        if (mismatches == 0 && statuses_due == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[car_stop_scheduler.f]
rtl/core/csched_pkg.sv
rtl/core/csched_call_if.sv
rtl/core/csched_status_if.sv
rtl/core/csched_step.sv
rtl/core/car_stop_scheduler.sv
sim/csched_checker.sv
sim/car_stop_scheduler_tb.sv
